/* rtl/lzrd_pkg.sv */
// shared constants and controller/datapath interface types for the lzss ring decompressor
// no dependencies
`default_nettype none

package lzrd_pkg;

  localparam int RING_DEPTH_DEF = 4096;
  localparam int RING_START     = 'hFEE;
  localparam logic [7:0] RING_FILL   = 8'h20;
  localparam logic [3:0] HDR_BYTES   = 4'd8;
  localparam logic [3:0] FLAG_BITS   = 4'd8;
  localparam logic [4:0] REF_MIN_LEN = 5'd3;

  // what an accepted stream byte means in the current decoder state
  typedef enum logic [2:0] {
    K_HDR,
    K_SKIP,
    K_FLAG,
    K_LOW,
    K_LIT,
    K_REF
  } kind_t;

  typedef struct packed {
    logic accept;
    logic lit_emit;
    logic rd_issue;
    logic copy_emit;
    logic end_emit;
    logic run_end;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  out_free;
    logic  copy_last;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/lzss_ring_decompressor_top.sv */
// lzss decoder, 4096-byte ring by default: one byte per input transfer, up to 19 results out.
// header/flag/low-reference bytes finish at accept; a literal then goes through S_LIT (result
// registered after accept); a reference alternates S_RD and S_WR for each copied byte,
// each byte being a registered ring read then a ring write; a final byte adds the end marker.
// synchronous active-low reset; ring contents are tracked by a fill count from the start
// position, so neither reset nor stream start needs a clearing pass.
// depends on lzrd_pkg, lzrd_ctrl, lzrd_dp, lzrd_ram
`default_nettype none

module lzss_ring_decompressor_top #(
  parameter int RING_DEPTH = lzrd_pkg::RING_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_last_of_run,
  output logic            out_stream_end
);
  import lzrd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  lzrd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_byte(in_last_byte),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  lzrd_dp #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_byte        (in_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last_of_run(out_last_of_run),
    .out_stream_end (out_stream_end)
  );

endmodule

`default_nettype wire

/* rtl/lzrd_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lzrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/lzrd_dp.sv */
// datapath: header limits, flag decoding, ring buffer with fill count, output register
// depends on lzrd_pkg and lzrd_ram
`default_nettype none

module lzrd_dp #(
  parameter int RING_DEPTH = lzrd_pkg::RING_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_byte,
  input  wire lzrd_pkg::dp_cmd_t cmd,
  output lzrd_pkg::dp_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_byte_valid,
  output logic                   out_last_of_run,
  output logic                   out_stream_end
);
  import lzrd_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] START_POS = AW'(RING_START);
  localparam logic [AW:0]   FULL_CNT  = (AW+1)'(RING_DEPTH);

  logic [3:0]    hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]   plimit_r, plimit_nxt;
  logic [31:0]   olimit_r, olimit_nxt;
  logic [31:0]   used_r, used_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [7:0]    flag_r, flag_nxt;
  logic [3:0]    flags_left_r, flags_left_nxt;
  logic [7:0]    low_r, low_nxt;
  logic          await_r, await_nxt;
  logic [7:0]    lit_r, lit_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [4:0]    len_r, len_nxt;
  logic [AW-1:0] wpos_r, wpos_nxt;
  logic [AW:0]   fill_r, fill_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_bv_r, out_bv_nxt;
  logic          out_lor_r, out_lor_nxt;
  logic          out_se_r, out_se_nxt;

  logic          hdr_done;
  logic          win_open;
  logic          out_free;
  logic          copy_last;
  logic          next_flag;
  logic          ring_we;
  logic [7:0]    ring_wdata;
  logic [7:0]    ring_rdata;
  logic [7:0]    copy_byte;
  logic [AW-1:0] rd_off;
  kind_t         kind;

  assign hdr_done  = (hdr_cnt_r == HDR_BYTES);
  assign win_open  = (used_r < plimit_r) && (prod_r < olimit_r);
  assign out_free  = !(out_valid_r && out_stall);
  assign copy_last = (len_r == 5'd1) || ((prod_r + 32'd1) == olimit_r);
  assign next_flag = cmd.lit_emit || (cmd.copy_emit && copy_last);

  // ring entries not yet written in this stream read as the fill byte
  assign rd_off    = pos_r - START_POS;
  assign copy_byte = rd_ok_r ? ring_rdata : RING_FILL;

  always_comb begin
    priority if (!hdr_done)            kind = K_HDR;
    else if (!win_open)                kind = K_SKIP;
    else if (flags_left_r == 4'd0)     kind = K_FLAG;
    else if (await_r)                  kind = K_REF;
    else if (flag_r[0])                kind = K_LIT;
    else                               kind = K_LOW;
  end

  assign sts.kind      = kind;
  assign sts.out_free  = out_free;
  assign sts.copy_last = copy_last;

  assign ring_we    = cmd.lit_emit || cmd.copy_emit;
  assign ring_wdata = cmd.lit_emit ? lit_r : copy_byte;

  lzrd_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ring_we),
    .wr_addr(wpos_r),
    .wr_data(ring_wdata),
    .rd_en  (cmd.rd_issue),
    .rd_addr(pos_r),
    .rd_data(ring_rdata)
  );

  always_comb begin
    hdr_cnt_nxt    = hdr_cnt_r;
    plimit_nxt     = plimit_r;
    olimit_nxt     = olimit_r;
    used_nxt       = used_r;
    prod_nxt       = prod_r;
    flag_nxt       = flag_r;
    flags_left_nxt = flags_left_r;
    low_nxt        = low_r;
    await_nxt      = await_r;
    lit_nxt        = lit_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    wpos_nxt       = wpos_r;
    fill_nxt       = fill_r;
    rd_ok_nxt      = rd_ok_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_bv_nxt     = out_bv_r;
    out_lor_nxt    = out_lor_r;
    out_se_nxt     = out_se_r;

    if (cmd.accept) begin
      unique case (kind)
        K_HDR: begin
          // little-endian limits shift in from the top
          if (hdr_cnt_r[3:2] == 2'b00) begin
            plimit_nxt = {in_byte, plimit_r[31:8]};
          end else begin
            olimit_nxt = {in_byte, olimit_r[31:8]};
          end
          hdr_cnt_nxt = hdr_cnt_r + 4'd1;
        end
        K_SKIP: begin
        end
        K_FLAG: begin
          flag_nxt       = in_byte;
          flags_left_nxt = FLAG_BITS;
          used_nxt       = used_r + 32'd1;
        end
        K_LOW: begin
          low_nxt   = in_byte;
          await_nxt = 1'b1;
          used_nxt  = used_r + 32'd1;
        end
        K_LIT: begin
          lit_nxt  = in_byte;
          used_nxt = used_r + 32'd1;
        end
        K_REF: begin
          pos_nxt  = AW'({in_byte[7:4], low_r});
          len_nxt  = {1'b0, in_byte[3:0]} + REF_MIN_LEN;
          used_nxt = used_r + 32'd1;
        end
        default: begin
        end
      endcase
    end

    if (cmd.rd_issue) begin
      rd_ok_nxt = fill_r[AW] || ({1'b0, rd_off} < fill_r);
    end

    if (ring_we) begin
      wpos_nxt = wpos_r + AW'(1);
      prod_nxt = prod_r + 32'd1;
      if (fill_r != FULL_CNT) begin
        fill_nxt = fill_r + (AW+1)'(1);
      end
      out_valid_nxt = 1'b1;
      out_byte_nxt  = ring_wdata;
      out_bv_nxt    = 1'b1;
      out_se_nxt    = 1'b0;
    end

    if (cmd.lit_emit) begin
      out_lor_nxt = cmd.run_end;
    end

    if (cmd.copy_emit) begin
      pos_nxt     = pos_r + AW'(1);
      len_nxt     = len_r - 5'd1;
      out_lor_nxt = cmd.run_end && copy_last;
      if (copy_last) begin
        await_nxt = 1'b0;
      end
    end

    if (next_flag) begin
      flag_nxt = {1'b0, flag_r[7:1]};
      if (flags_left_r != 4'd0) begin
        flags_left_nxt = flags_left_r - 4'd1;
      end
    end

    if (cmd.end_emit) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = 8'h00;
      out_bv_nxt     = 1'b0;
      out_lor_nxt    = 1'b1;
      out_se_nxt     = 1'b1;
      // fresh stream: fill count zero makes the whole ring read as fill bytes
      hdr_cnt_nxt    = 4'd0;
      plimit_nxt     = 32'd0;
      olimit_nxt     = 32'd0;
      used_nxt       = 32'd0;
      prod_nxt       = 32'd0;
      flag_nxt       = 8'h00;
      flags_left_nxt = 4'd0;
      low_nxt        = 8'h00;
      await_nxt      = 1'b0;
      wpos_nxt       = START_POS;
      fill_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r    <= 4'd0;
      plimit_r     <= 32'd0;
      olimit_r     <= 32'd0;
      used_r       <= 32'd0;
      prod_r       <= 32'd0;
      flag_r       <= 8'h00;
      flags_left_r <= 4'd0;
      low_r        <= 8'h00;
      await_r      <= 1'b0;
      len_r        <= 5'd0;
      wpos_r       <= START_POS;
      fill_r       <= '0;
      rd_ok_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hdr_cnt_r    <= hdr_cnt_nxt;
      plimit_r     <= plimit_nxt;
      olimit_r     <= olimit_nxt;
      used_r       <= used_nxt;
      prod_r       <= prod_nxt;
      flag_r       <= flag_nxt;
      flags_left_r <= flags_left_nxt;
      low_r        <= low_nxt;
      await_r      <= await_nxt;
      len_r        <= len_nxt;
      wpos_r       <= wpos_nxt;
      fill_r       <= fill_nxt;
      rd_ok_r      <= rd_ok_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_r      <= lit_nxt;
    pos_r      <= pos_nxt;
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_lor_r  <= out_lor_nxt;
    out_se_r   <= out_se_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_valid  = out_bv_r;
  assign out_last_of_run = out_lor_r;
  assign out_stream_end  = out_se_r;

  a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bv_r) |-> (out_se_r && out_lor_r && out_byte_r == 8'h00))
    else $error("end marker without stream_end");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("ring fill count overflow");

  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_emit |-> (len_r != 5'd0 && prod_r < olimit_r))
    else $error("copy byte emitted past length or output limit");

endmodule

`default_nettype wire

/* rtl/lzrd_ctrl.sv */
// controller state machine: sequences accept, literal, reference copy and end marker
// depends on lzrd_pkg
`default_nettype none

module lzrd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last_byte,
  output logic                   in_stall,
  input  wire lzrd_pkg::dp_sts_t sts,
  output lzrd_pkg::dp_cmd_t      cmd
);
  import lzrd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIT,
    S_RD,
    S_WR,
    S_END
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.run_end = !last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          last_nxt   = in_last_byte;
          unique case (sts.kind)
            K_LIT:   state_nxt = S_LIT;
            K_REF:   state_nxt = S_RD;
            default: state_nxt = in_last_byte ? S_END : S_IDLE;
          endcase
        end
      end
      S_LIT: begin
        if (sts.out_free) begin
          cmd.lit_emit = 1'b1;
          state_nxt    = last_r ? S_END : S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_WR;
      end
      S_WR: begin
        // ring data held in the read register until the output slot frees up
        if (sts.out_free) begin
          cmd.copy_emit = 1'b1;
          if (sts.copy_last) begin
            state_nxt = last_r ? S_END : S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.end_emit = 1'b1;
          last_nxt     = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  a_wr_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR && !sts.out_free) |=> (state_r == S_WR))
    else $error("copy byte dropped while output stalled");

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_END && sts.out_free) |=> (state_r == S_IDLE && !last_r))
    else $error("stream end did not return to idle");

endmodule

`default_nettype wire
